// ===== rtl/core/ntm_pkg.sv =====
// ----------------------------------------------------------------------------
// ntm_pkg - shared types and constants for the NTC thermistor monitor
// Field widths, action and status codes, config register indexes and the
// reference-voltage helper used by the datapath and the status unit.
// ----------------------------------------------------------------------------
package ntm_pkg;

  // Curve table geometry
  localparam int TABLE_NODES = 33;
  localparam int NODE_AW     = $clog2(TABLE_NODES);
  localparam int SEG_AW      = 5;
  localparam int STEP_SHIFT  = 7;

  // Field widths
  localparam int RAW_W      = 12;
  localparam int TEMP_W     = 16;
  localparam int MV_W       = 13;
  localparam int VREF_W     = 13;
  localparam int CFG_TEMP_W = 13;
  localparam int CNT_W      = 8;
  localparam int DB_W       = 7;
  localparam int CFG_AW     = 3;
  localparam int PROD_W     = RAW_W + VREF_W;
  localparam int STEP_PROD_W = TEMP_W + 1 + STEP_SHIFT + 1;

  // Conversion constants
  localparam logic [VREF_W-1:0] DEFAULT_VREF   = 13'd3300;
  localparam logic [RAW_W-1:0]  RAW_FULL       = 12'd4095;
  localparam logic [DB_W-1:0]   DEADBAND_MIN   = 7'd20;
  // vref / 100 == (vref * 5243) >> 19 for every 13-bit vref
  localparam logic [VREF_W-1:0] DB_RECIP       = 13'd5243;
  localparam int                DB_RECIP_SHIFT = 19;

  // Output queue depth default
  localparam int OUT_DEPTH_DEF = 8;

  // Config register indexes
  typedef logic [CFG_AW-1:0] cfg_addr_t;
  localparam cfg_addr_t CFG_VREF_MV   = 3'd0;
  localparam cfg_addr_t CFG_PULL_UP   = 3'd1;
  localparam cfg_addr_t CFG_DEBOUNCE  = 3'd2;
  localparam cfg_addr_t CFG_MAX_TEMP  = 3'd3;
  localparam cfg_addr_t CFG_MIN_TEMP  = 3'd4;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_HW_FAULT    = 3'd1,
    ST_DEBOUNCE    = 3'd2,
    ST_OVER_TEMP   = 3'd3,
    ST_UNDER_RANGE = 3'd4
  } status_e;

  typedef struct packed {
    logic [VREF_W-1:0]            vref_mv;
    logic                         divider_pull_up;
    logic [CNT_W-1:0]             debounce_threshold;
    logic signed [CFG_TEMP_W-1:0] max_valid_temp;
    logic signed [CFG_TEMP_W-1:0] min_valid_temp;
  } cfg_t;

  // Item leaving the arithmetic pipeline
  typedef struct packed {
    logic                          valid;
    action_e                       action;
    logic [MV_W-1:0]               mv;
    logic signed [TEMP_W-1:0]      y0;
    logic signed [STEP_PROD_W-1:0] step;
  } stage_t;

  typedef struct packed {
    status_e                  status;
    logic signed [TEMP_W-1:0] temp_tenths;
    logic [MV_W-1:0]          millivolts;
    logic                     open_fault;
    logic                     short_fault;
  } result_t;

  // A zero reference selects the default
  function automatic logic [VREF_W-1:0] eff_vref(input logic [VREF_W-1:0] v);
    return (v == '0) ? DEFAULT_VREF : v;
  endfunction

endpackage

// ===== rtl/core/ntm_curve_mem.sv =====
// ----------------------------------------------------------------------------
// ntm_curve_mem - thermistor curve table
// 33 x 16-bit synchronous memory, one write port and two registered read
// ports that fetch the two nodes bounding a 128-code segment.
// ----------------------------------------------------------------------------
module ntm_curve_mem import ntm_pkg::*; (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [NODE_AW-1:0]       wr_addr,
  input  logic [TEMP_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [SEG_AW-1:0]        rd_seg,
  output logic signed [TEMP_W-1:0] rd_lo,
  output logic signed [TEMP_W-1:0] rd_hi
);

  logic [TEMP_W-1:0]  mem [TABLE_NODES];
  logic [NODE_AW-1:0] addr_lo;
  logic [NODE_AW-1:0] addr_hi;

  // Lower node and the one after it
  assign addr_lo = NODE_AW'(rd_seg);
  assign addr_hi = addr_lo + 1'b1;

  // Write node
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read both bounding nodes
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_lo <= signed'(mem[addr_lo]);
      rd_hi <= signed'(mem[addr_hi]);
    end
  end

endmodule

// ===== rtl/core/ntm_datapath.sv =====
// ----------------------------------------------------------------------------
// ntm_datapath - millivolt conversion and interpolation pipeline
// Three stages: raw*vref product, divide-by-4095 estimate and node delta,
// estimate correction and delta*fraction product.
// ----------------------------------------------------------------------------
module ntm_datapath import ntm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  action_e                  in_action,
  input  logic [RAW_W-1:0]         in_raw,
  input  logic [VREF_W-1:0]        vref_mv,
  input  logic signed [TEMP_W-1:0] node_lo,
  input  logic signed [TEMP_W-1:0] node_hi,
  output stage_t                   s3
);

  localparam int QUO_W = PROD_W + 1 - RAW_W;

  // Stage 1
  logic                     v1;
  action_e                  act1;
  logic [STEP_SHIFT-1:0]    frac1;
  logic [PROD_W-1:0]        prod1;
  // Stage 2
  logic                     v2;
  action_e                  act2;
  logic [STEP_SHIFT-1:0]    frac2;
  logic [PROD_W-1:0]        prod2;
  logic [QUO_W-1:0]         est2;
  logic signed [TEMP_W:0]   diff2;
  logic signed [TEMP_W-1:0] y0_2;
  // Combinational
  logic [VREF_W-1:0]        vref_eff;
  logic [PROD_W:0]          est_sum;
  logic [PROD_W:0]          est_back;
  logic [PROD_W:0]          rem;
  logic [QUO_W-1:0]         mv_full;

  assign vref_eff = eff_vref(vref_mv);

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  // Stage 1: product raw * vref
  always_ff @(posedge clk) begin
    act1  <= in_action;
    frac1 <= in_raw[STEP_SHIFT-1:0];
    prod1 <= PROD_W'(in_raw) * PROD_W'(vref_eff);
  end

  // Divide by 2^12-1: p/4095 ~ (p + p>>12 + p>>24) >> 12, low by at most one
  assign est_sum = {1'b0, prod1} + (PROD_W+1)'(prod1 >> RAW_W)
                 + (PROD_W+1)'(prod1 >> (2 * RAW_W));

  // Stage 2: quotient estimate and node delta
  always_ff @(posedge clk) begin
    act2  <= act1;
    frac2 <= frac1;
    prod2 <= prod1;
    est2  <= est_sum[PROD_W:RAW_W];
    diff2 <= (TEMP_W+1)'(node_hi) - (TEMP_W+1)'(node_lo);
    y0_2  <= node_lo;
  end

  // Correct the estimate with one compare
  assign est_back = {est2, RAW_W'(0)} - (PROD_W+1)'(est2);
  assign rem      = {1'b0, prod2} - est_back;
  assign mv_full  = est2 + QUO_W'(rem >= (PROD_W+1)'(RAW_FULL));

  // Stage 3: millivolts and interpolation step product
  always_ff @(posedge clk) begin
    if (rst) begin
      s3.valid <= 1'b0;
    end else begin
      s3.valid <= v2;
    end
    s3.action <= act2;
    s3.mv     <= mv_full[MV_W-1:0];
    s3.y0     <= y0_2;
    s3.step   <= STEP_PROD_W'(diff2) * STEP_PROD_W'(signed'({1'b0, frac2}));
  end

endmodule

// ===== rtl/core/ntm_status_unit.sv =====
// ----------------------------------------------------------------------------
// ntm_status_unit - fault detection, debounce and temperature range check
// Holds the latched fault flags, the fault run counter and the last
// temperature, and registers one result per item.
// ----------------------------------------------------------------------------
module ntm_status_unit import ntm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  stage_t  s3,
  output logic    res_valid,
  output result_t res
);

  // Thresholds derived from config
  logic [VREF_W-1:0]              vref_eff;
  logic [2*VREF_W-1:0]            db_prod;
  logic [DB_W-1:0]                db_quo;
  logic [DB_W-1:0]                db_r;
  logic [VREF_W-1:0]              hi_r;
  logic signed [TEMP_W:0]         hi_t_r;
  logic signed [TEMP_W:0]         lo_t_r;
  // State
  logic                           open_l, open_next;
  logic                           short_l, short_next;
  logic [CNT_W-1:0]               run_cnt, run_cnt_next;
  logic signed [TEMP_W-1:0]       last_temp, last_temp_next;
  // Combinational
  logic signed [STEP_PROD_W-1:0]  step_sh;
  logic signed [TEMP_W:0]         t_full;
  logic                           le_db;
  logic                           ge_hi;
  logic                           short_hit;
  logic                           open_hit;
  logic [CNT_W-1:0]               cnt_inc;
  logic                           fire;
  result_t                        res_next;

  assign vref_eff = eff_vref(cfg.vref_mv);
  assign db_prod  = (2*VREF_W)'(vref_eff) * (2*VREF_W)'(DB_RECIP);
  assign db_quo   = db_prod[DB_RECIP_SHIFT +: DB_W];

  // Follow config: deadband, upper threshold, window in tenths
  always_ff @(posedge clk) begin
    db_r   <= (db_quo < DEADBAND_MIN) ? DEADBAND_MIN : db_quo;
    hi_r   <= (vref_eff > VREF_W'(db_r)) ? vref_eff - VREF_W'(db_r) : '0;
    hi_t_r <= (TEMP_W+1)'(cfg.max_valid_temp) * 17'sd10;
    lo_t_r <= (TEMP_W+1)'(cfg.min_valid_temp) * 17'sd10;
  end

  // Interpolated temperature, step floored
  assign step_sh = s3.step >>> STEP_SHIFT;
  assign t_full  = (TEMP_W+1)'(s3.y0) + signed'(step_sh[TEMP_W:0]);

  // Short / open classification by divider polarity
  assign le_db = s3.mv <= MV_W'(db_r);
  assign ge_hi = s3.mv >= hi_r;
  always_comb begin
    if (cfg.divider_pull_up) begin
      short_hit = le_db;
      open_hit  = !le_db && ge_hi;
    end else begin
      short_hit = ge_hi;
      open_hit  = !ge_hi && le_db;
    end
  end

  assign cnt_inc = (run_cnt != '1) ? run_cnt + 1'b1 : run_cnt;
  assign fire    = (cfg.debounce_threshold == '0) || (cnt_inc >= cfg.debounce_threshold);

  // Next state and result
  always_comb begin
    open_next      = open_l;
    short_next     = short_l;
    run_cnt_next   = run_cnt;
    last_temp_next = last_temp;
    res_next       = '0;
    res_next.status = ST_OK;
    if (s3.valid) begin
      case (s3.action)
        ACT_SAMPLE: begin
          res_next.millivolts = s3.mv;
          if (open_l || short_l) begin
            res_next.status = ST_HW_FAULT;
          end else if (short_hit || open_hit) begin
            if (fire) begin
              run_cnt_next    = cfg.debounce_threshold;
              short_next      = short_hit;
              open_next       = open_hit;
              res_next.status = ST_HW_FAULT;
            end else begin
              run_cnt_next    = cnt_inc;
              res_next.status = ST_DEBOUNCE;
            end
          end else begin
            run_cnt_next   = '0;
            last_temp_next = t_full[TEMP_W-1:0];
            if (t_full > hi_t_r) begin
              res_next.status = ST_OVER_TEMP;
            end else if (t_full < lo_t_r) begin
              res_next.status = ST_UNDER_RANGE;
            end
          end
        end
        ACT_CLEAR: begin
          open_next    = 1'b0;
          short_next   = 1'b0;
          run_cnt_next = '0;
        end
        default: begin
        end
      endcase
    end
    res_next.temp_tenths = last_temp_next;
    res_next.open_fault  = open_next;
    res_next.short_fault = short_next;
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      open_l    <= 1'b0;
      short_l   <= 1'b0;
      run_cnt   <= '0;
      last_temp <= '0;
      res_valid <= 1'b0;
    end else begin
      open_l    <= open_next;
      short_l   <= short_next;
      run_cnt   <= run_cnt_next;
      last_temp <= last_temp_next;
      res_valid <= s3.valid;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  // Only one fault kind can be latched at a time
  a_one_fault: assert property (@(posedge clk) disable iff (rst)
    !(open_l && short_l))
    else $error("open and short faults latched together");

  // A latched fault blocks every sample
  a_latched_blocks: assert property (@(posedge clk) disable iff (rst)
    (s3.valid && s3.action == ACT_SAMPLE && (open_l || short_l))
      |=> (res_valid && res.status == ST_HW_FAULT))
    else $error("sample passed a latched fault");

  // Clear drops both flags
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (s3.valid && s3.action == ACT_CLEAR) |=> (!open_l && !short_l && run_cnt == '0))
    else $error("clear left fault state behind");

endmodule

// ===== rtl/core/ntm_out_fifo.sv =====
// ----------------------------------------------------------------------------
// ntm_out_fifo - result queue
// Small register queue between the status stage and the output stream.
// ----------------------------------------------------------------------------
module ntm_out_fifo import ntm_pkg::*; #(
  parameter int DEPTH = OUT_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t din,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t dout
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  result_t         entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign dout      = entries[rd_ptr];

  // Store item
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Credit at the input keeps the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != CW'(DEPTH) || pop))
    else $error("result queue overflow");

endmodule

// ===== rtl/core/ntc_thermistor_monitor.sv =====
// ----------------------------------------------------------------------------
// ntc_thermistor_monitor - NTC thermistor monitor, table interpolation
// Converts ADC samples to millivolts and tenths of a degree, with debounced
// and latched short/open detection.
// ----------------------------------------------------------------------------
// The block takes one item per clock and returns exactly one result per item,
// in order, through three arithmetic stages (product, divide-by-4095,
// interpolation multiply), the status register and the result queue. An item
// that loads a table node writes the curve memory in the cycle it is accepted,
// so a sample accepted in the next cycle already reads the new node. Up to
// OUT_DEPTH items may be outstanding; when that many results are not yet
// taken, s_axis_tready drops until the output side drains, so the sustained
// rate is one item per cycle whenever m_axis_tready stays high. The curve
// table has no reset and must be loaded before samples are sent; the user
// must write configuration only while no item is outstanding (not enforced).
// ----------------------------------------------------------------------------
module ntc_thermistor_monitor import ntm_pkg::*; #(
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // raw_sample[11:0], node_index[17:12], node_value[33:18], zero pad [39:34]
  input  logic [39:0]       s_axis_tdata,
  // action[1:0]
  input  logic [1:0]        s_axis_tuser,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // temp_tenths[15:0], millivolts[28:16], open_fault[29], short_fault[30],
  // zero pad [31]
  output logic [31:0]       m_axis_tdata,
  // status[2:0]
  output logic [2:0]        m_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [VREF_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(OUT_DEPTH + 1);

  cfg_t                     cfg;
  logic [CW-1:0]            pending;
  logic                     s_accept;
  logic                     m_accept;
  action_e                  in_action;
  logic [RAW_W-1:0]         in_raw;
  logic [NODE_AW-1:0]       in_node_index;
  logic [TEMP_W-1:0]        in_node_value;
  logic                     node_wr;
  logic signed [TEMP_W-1:0] node_lo;
  logic signed [TEMP_W-1:0] node_hi;
  stage_t                   s3;
  logic                     res_valid;
  result_t                  res;
  result_t                  dout;

  // Unpack input item
  assign in_action     = action_e'(s_axis_tuser);
  assign in_raw        = s_axis_tdata[11:0];
  assign in_node_index = s_axis_tdata[17:12];
  assign in_node_value = s_axis_tdata[33:18];

  assign s_axis_tready = (pending < CW'(OUT_DEPTH));
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_accept      = m_axis_tvalid && m_axis_tready;
  assign node_wr       = s_accept && (in_action == ACT_WRITE)
                       && (in_node_index < NODE_AW'(TABLE_NODES));

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vref_mv            <= DEFAULT_VREF;
      cfg.divider_pull_up    <= 1'b1;
      cfg.debounce_threshold <= '0;
      cfg.max_valid_temp     <= 13'sd125;
      cfg.min_valid_temp     <= -13'sd40;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_VREF_MV:  cfg.vref_mv            <= cfg_wdata;
        CFG_PULL_UP:  cfg.divider_pull_up    <= cfg_wdata[0];
        CFG_DEBOUNCE: cfg.debounce_threshold <= cfg_wdata[CNT_W-1:0];
        CFG_MAX_TEMP: cfg.max_valid_temp     <= signed'(cfg_wdata);
        CFG_MIN_TEMP: cfg.min_valid_temp     <= signed'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  // Count items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({s_accept, m_accept})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  ntm_curve_mem u_curve_mem (
    .clk     (clk),
    .wr_en   (node_wr),
    .wr_addr (in_node_index),
    .wr_data (in_node_value),
    .rd_en   (s_accept),
    .rd_seg  (in_raw[RAW_W-1:STEP_SHIFT]),
    .rd_lo   (node_lo),
    .rd_hi   (node_hi)
  );

  ntm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_accept),
    .in_action (in_action),
    .in_raw    (in_raw),
    .vref_mv   (cfg.vref_mv),
    .node_lo   (node_lo),
    .node_hi   (node_hi),
    .s3        (s3)
  );

  ntm_status_unit u_status_unit (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s3        (s3),
    .res_valid (res_valid),
    .res       (res)
  );

  ntm_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .din       (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .dout      (dout)
  );

  // Pack result item
  assign m_axis_tdata = {1'b0, dout.short_fault, dout.open_fault, dout.millivolts,
                         dout.temp_tenths};
  assign m_axis_tuser = dout.status;

  // A result on the output always belongs to an outstanding item
  a_result_owned: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (pending != '0))
    else $error("result without an outstanding item");

endmodule

// ===== tb/ntc_thermistor_monitor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_thermistor_monitor_tb - self-checking bench for the thermistor monitor
// Loads the curve table, runs directed corner items, then random item streams
// under several register settings and idle/stall patterns. Every result is
// predicted in-bench and compared field by field, in order.
// ----------------------------------------------------------------------------
module ntc_thermistor_monitor_tb;
  import ntm_pkg::*;

  // Action code the block does not define; it must behave as a no-op item
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;

  // Predictor of the monitor plus the queue of readings still to arrive
  class temp_reading_board;
    logic [VREF_W-1:0]        vref_mv;
    logic                     pull_up;
    logic [CNT_W-1:0]         debounce_thr;
    logic signed [CFG_TEMP_W-1:0] max_deg;
    logic signed [CFG_TEMP_W-1:0] min_deg;
    logic signed [TEMP_W-1:0] curve [TABLE_NODES];
    logic                     open_flag;
    logic                     short_flag;
    logic [CNT_W-1:0]         run_count;
    logic signed [TEMP_W-1:0] last_temp;
    result_t                  expected_readings [$];
    int                       failures;

    function new();
      vref_mv      = DEFAULT_VREF;
      pull_up      = 1'b1;
      debounce_thr = '0;
      max_deg      = 13'sd125;
      min_deg      = -13'sd40;
      foreach (curve[i]) curve[i] = '0;
      open_flag    = 1'b0;
      short_flag   = 1'b0;
      run_count    = '0;
      last_temp    = '0;
      failures     = 0;
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    function void write_reg(cfg_addr_t addr, logic [VREF_W-1:0] value);
      case (addr)
        CFG_VREF_MV:  vref_mv      = value;
        CFG_PULL_UP:  pull_up      = value[0];
        CFG_DEBOUNCE: debounce_thr = value[CNT_W-1:0];
        CFG_MAX_TEMP: max_deg      = value;
        CFG_MIN_TEMP: min_deg      = value;
        default: ;
      endcase
    endfunction

    // Linear step between two nodes; the step rounds toward minus infinity
    function int interp(logic [RAW_W-1:0] raw);
      int seg, frac, y0, y1, d;
      seg  = raw[RAW_W-1:STEP_SHIFT];
      frac = raw[STEP_SHIFT-1:0];
      y0   = curve[seg];
      y1   = curve[seg + 1];
      d    = (y1 - y0) * frac;
      return y0 + (d >>> STEP_SHIFT);
    endfunction

    // Predict the reading caused by one accepted item
    function void note_item(logic [1:0] action, logic [RAW_W-1:0] raw,
                            logic [5:0] node, logic [TEMP_W-1:0] value);
      result_t r;
      int vref, mv, db, hi, t, hi_t, lo_t;
      bit short_hit, open_hit, fire;
      r.status     = ST_OK;
      r.millivolts = '0;
      if (action == ACT_SAMPLE) begin
        vref = (vref_mv == 0) ? int'(DEFAULT_VREF) : int'(vref_mv);
        mv = int'(raw) * vref / 4095;
        r.millivolts = mv[MV_W-1:0];
        if (open_flag || short_flag) begin
          r.status = ST_HW_FAULT;
        end else begin
          db = vref / 100;
          if (db < 20) db = 20;
          hi = (vref > db) ? vref - db : 0;
          short_hit = 1'b0;
          open_hit  = 1'b0;
          if (pull_up) begin
            if (mv <= db) short_hit = 1'b1;
            else if (mv >= hi) open_hit = 1'b1;
          end else begin
            if (mv >= hi) short_hit = 1'b1;
            else if (mv <= db) open_hit = 1'b1;
          end
          if (short_hit || open_hit) begin
            // debounce: count the run, latch once it reaches the threshold
            fire = (debounce_thr == 0);
            if (!fire) begin
              if (run_count != 8'd255) run_count = run_count + 1'b1;
              fire = (run_count >= debounce_thr);
            end
            if (fire) begin
              run_count = debounce_thr;
              if (short_hit) short_flag = 1'b1;
              if (open_hit) open_flag = 1'b1;
              r.status = ST_HW_FAULT;
            end else begin
              r.status = ST_DEBOUNCE;
            end
          end else begin
            run_count = '0;
            t = interp(raw);
            last_temp = t[TEMP_W-1:0];
            hi_t = max_deg;
            lo_t = min_deg;
            hi_t = hi_t * 10;
            lo_t = lo_t * 10;
            if (t > hi_t) r.status = ST_OVER_TEMP;
            else if (t < lo_t) r.status = ST_UNDER_RANGE;
          end
        end
      end else if (action == ACT_WRITE) begin
        if (node < TABLE_NODES) curve[node] = value;
      end else if (action == ACT_CLEAR) begin
        open_flag  = 1'b0;
        short_flag = 1'b0;
        run_count  = '0;
      end
      r.temp_tenths = last_temp;
      r.open_fault  = open_flag;
      r.short_fault = short_flag;
      expected_readings.push_back(r);
    endfunction

    function void flag(string what, int want, int got);
      if (failures < 10) $display("mismatch on %s: expected %0d, got %0d", what, want, got);
      failures++;
    endfunction

    // Compare one accepted reading with the oldest prediction
    function void check_reading(logic [2:0] status, logic [31:0] data);
      result_t r;
      if (expected_readings.size() == 0) begin
        flag("unexpected reading, status", -1, status);
        return;
      end
      r = expected_readings.pop_front();
      if (status !== r.status) flag("status", r.status, status);
      if (data[15:0] !== r.temp_tenths)
        flag("temp_tenths", r.temp_tenths, $signed(data[15:0]));
      if (data[28:16] !== r.millivolts) flag("millivolts", r.millivolts, data[28:16]);
      if (data[29] !== r.open_fault) flag("open_fault", r.open_fault, data[29]);
      if (data[30] !== r.short_fault) flag("short_fault", r.short_fault, data[30]);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic [39:0]       s_axis_tdata = '0;
  logic [1:0]        s_axis_tuser = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       m_axis_tdata;
  logic [2:0]        m_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [VREF_W-1:0] cfg_wdata = '0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  temp_reading_board readings = new();

  ntc_thermistor_monitor dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Stall the output side at random
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Check every accepted reading
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      readings.check_reading(m_axis_tuser, m_axis_tdata);
  end

  // Abort when neither side moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one item, with random idle cycles ahead of it; starts and ends at negedge
  task automatic send_item(logic [1:0] action, logic [RAW_W-1:0] raw,
                           logic [5:0] node, logic [TEMP_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= action;
    s_axis_tdata  <= {6'd0, value, node, raw};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    readings.note_item(action, raw, node, value);
    @(negedge clk);
  endtask

  task automatic put_reg(cfg_addr_t addr, logic [VREF_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    readings.write_reg(addr, value);
    @(negedge clk);
  endtask

  // Write all five registers back to back, then drop the write enable
  task automatic apply_settings(int vref, int pull, int thr, int max_d, int min_d);
    put_reg(CFG_VREF_MV, 13'(vref));
    put_reg(CFG_PULL_UP, 13'(pull));
    put_reg(CFG_DEBOUNCE, 13'(thr));
    put_reg(CFG_MAX_TEMP, 13'(max_d));
    put_reg(CFG_MIN_TEMP, 13'(min_d));
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Samples lean toward both ends of the scale, where the fault checks sit
  function automatic logic [RAW_W-1:0] pick_raw();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return 12'($urandom);
    if (pick < 70) return 12'($urandom_range(0, 90));
    return 12'($urandom_range(4000, 4095));
  endfunction

  task automatic run_random(int count);
    int pick;
    logic [5:0] node;
    logic [TEMP_W-1:0] value;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_item(ACT_SAMPLE, pick_raw(), 6'($urandom), 16'($urandom));
      end else if (pick < 80) begin
        send_item(ACT_CLEAR, 12'($urandom), 6'($urandom), 16'($urandom));
      end else if (pick < 92) begin
        node = ($urandom_range(99) < 85) ? 6'($urandom_range(0, 32))
                                         : 6'($urandom_range(33, 63));
        value = ($urandom_range(1) == 0) ? 16'($urandom_range(0, 4000) - 2000)
                                         : 16'($urandom);
        send_item(ACT_WRITE, 12'($urandom), node, value);
      end else begin
        send_item(ACT_UNUSED, 12'($urandom), 6'($urandom), 16'($urandom));
      end
    end
  endtask

  // Drain, retune registers and idle pattern, send any fault run, then random items
  task automatic run_phase(int mode, int vref, int pull, int thr, int max_d, int min_d,
                           int fault_run, int count);
    s_axis_tvalid <= 1'b0;
    while (readings.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    apply_settings(vref, pull, thr, max_d, min_d);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 83; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 83; end
      default: begin send_idle_pct = 38; stall_pct = 38; end
    endcase
    // hold a sample in the short band long enough to saturate the run counter
    for (int n = 0; n < fault_run; n++)
      send_item(ACT_SAMPLE, 12'($urandom_range(0, 20)), 6'($urandom), 16'($urandom));
    if (fault_run != 0) send_item(ACT_CLEAR, '0, '0, '0);
    run_random(count);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);
    apply_settings(3300, 1, 0, 125, -40);

    // Load a falling curve so every segment is defined before any sample
    for (int i = 0; i < TABLE_NODES; i++)
      send_item(ACT_WRITE, '0, 6'(i), 16'(1250 - i * 45 + $urandom_range(0, 20)));

    // Directed corners: fault latching and clearing, ignored items, table extremes
    send_item(ACT_SAMPLE, 12'd0, 6'h3f, 16'hffff);
    send_item(ACT_SAMPLE, 12'd2048, '0, '0);
    send_item(ACT_CLEAR, 12'hfff, 6'h3f, 16'hffff);
    send_item(ACT_SAMPLE, 12'd4095, '0, '0);
    send_item(ACT_UNUSED, 12'hfff, 6'h3f, 16'hffff);
    send_item(ACT_SAMPLE, 12'd1000, '0, '0);
    send_item(ACT_CLEAR, '0, '0, '0);
    send_item(ACT_SAMPLE, 12'd1000, '0, '0);
    send_item(ACT_WRITE, '0, 6'd33, 16'h7fff);
    send_item(ACT_WRITE, '0, 6'd63, 16'h8000);
    send_item(ACT_WRITE, '0, 6'd16, 16'h7fff);
    send_item(ACT_WRITE, '0, 6'd17, 16'h8000);
    send_item(ACT_SAMPLE, 12'd2048, '0, '0);
    send_item(ACT_SAMPLE, 12'd2175, '0, '0);
    send_item(ACT_SAMPLE, 12'd2176, '0, '0);
    send_item(ACT_WRITE, '0, 6'd5, 16'd100);
    send_item(ACT_WRITE, '0, 6'd6, 16'd99);
    send_item(ACT_SAMPLE, 12'd641, '0, '0);
    send_item(ACT_SAMPLE, 12'd3990, '0, '0);
    send_item(ACT_WRITE, '0, 6'd16, 16'd530);
    send_item(ACT_WRITE, '0, 6'd17, 16'd485);
    send_item(ACT_SAMPLE, 12'd2200, '0, '0);

    // Register settings, extremes first, then random ones
    run_phase(0, 3300, 1, 0, 125, -40, 0, 150);
    run_phase(1, 0, 0, 3, 3276, -3276, 0, 150);
    run_phase(2, 6000, 1, 255, -3276, 3276, 260, 150);
    run_phase(3, 1, 0, 1, 50, -20, 0, 120);
    for (int p = 4; p < 8; p++)
      run_phase(p % 4, $urandom_range(0, 6000), $urandom_range(1), $urandom_range(0, 6),
                $urandom_range(0, 400) - 100, $urandom_range(0, 400) - 300, 0, 150);

    s_axis_tvalid <= 1'b0;
    while (readings.pending() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (readings.failures == 0 && readings.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
